### rtl/tws_pkg.sv
package tws_pkg;

  // Default sizes of the wheel and the task table
  localparam int WHEEL_SLOTS_DEF  = 100;
  localparam int TICK_MS_DEF      = 10;
  localparam int TASK_ENTRIES_DEF = 16;

  // Period store is 13 bits wide; longer periods saturate
  localparam int          PER_W      = 13;
  localparam logic [12:0] PERIOD_MAX = 13'd8191;

  // Shared divider widths: dividend covers ms value plus wheel position,
  // divisor covers the largest tick length and wheel size
  localparam int DVD_W = 17;
  localparam int DVS_W = 11;

  // Command codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // Command context seen by the head of the ring
  typedef struct packed {
    logic [1:0] opcode;
    logic       placed;
  } head_ctl_t;

  // What the head did to the entry passing it this cycle
  typedef struct packed {
    logic fire;
    logic place;
    logic drop;
  } head_evt_t;

endpackage

### rtl/timing_wheel_task_scheduler_core.sv
// Channel   Ports                                               Transfer
// command   start, busy, opcode, task_code, delay_ms,           start & !busy
//           period_ms, target_id
// result    strobe, status, assigned_id, fired, fired_code,     strobe (1 cycle)
//           last
//
// For tick, delete and the unused code, the task table, a ring of cells,
// is rotated once past a single head stage before the final result.
// Add first runs four passes of the shared reciprocal divider to convert
// delay and period to slots, then rotates the ring in the same way.
// Reset clears all valid flags and the wheel position.
// The result side cannot stall; busy holds off commands until the
// final result has been issued.
module timing_wheel_task_scheduler_core import tws_pkg::*; #(
  parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
  parameter int TICK_MS      = TICK_MS_DEF,
  parameter int TASK_ENTRIES = TASK_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  task_code,
  input  logic [15:0] delay_ms,
  input  logic [15:0] period_ms,
  input  logic [3:0]  target_id,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [3:0]  assigned_id,
  output logic        fired,
  output logic [7:0]  fired_code,
  output logic        last
);

  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int IW = $clog2(TASK_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_DLY, S_DIV_SLOT, S_DIV_PER, S_DIV_PMOD, S_SCAN, S_FINISH
  } state_t;

  state_t           state;
  logic [SW-1:0]    pos;
  logic [IW-1:0]    idx;
  logic [1:0]       op_r;
  logic [7:0]       code_r;
  logic [15:0]      per_r;
  logic [3:0]       tgt_r;
  logic             placed;
  logic [IW-1:0]    place_id;
  logic             del_ok;
  logic             pend_v;
  logic [7:0]       pend_code;
  logic [SW-1:0]    add_slot;
  logic [SW-1:0]    add_pmod;
  logic             add_periodic;

  logic             div_go;
  logic             div_wheel;
  logic [DVD_W-1:0] div_dvd;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  // Ring of entries; cell 0 feeds the head, the head feeds the last cell
  logic          c_valid    [TASK_ENTRIES];
  logic          c_periodic [TASK_ENTRIES];
  logic [SW-1:0] c_slot     [TASK_ENTRIES];
  logic [SW-1:0] c_pmod     [TASK_ENTRIES];
  logic [7:0]    c_code     [TASK_ENTRIES];

  logic          h_valid;
  logic          h_periodic;
  logic [SW-1:0] h_slot;
  logic [SW-1:0] h_pmod;
  logic [7:0]    h_code;
  head_ctl_t     ctl;
  head_evt_t     evt;
  logic          shift;

  assign busy  = (state != S_IDLE);
  assign shift = (state == S_SCAN);
  assign ctl   = '{opcode: op_r, placed: placed};

  tws_div #(
    .TICK_MS     (TICK_MS),
    .WHEEL_SLOTS (WHEEL_SLOTS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .by_wheel  (div_wheel),
    .dividend  (div_dvd),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  for (genvar g = 0; g < TASK_ENTRIES; g++) begin : g_ring
    if (g == TASK_ENTRIES - 1) begin : g_tail
      tws_cell #(.SW(SW)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .d_valid    (h_valid),
        .d_periodic (h_periodic),
        .d_slot     (h_slot),
        .d_pmod     (h_pmod),
        .d_code     (h_code),
        .q_valid    (c_valid[g]),
        .q_periodic (c_periodic[g]),
        .q_slot     (c_slot[g]),
        .q_pmod     (c_pmod[g]),
        .q_code     (c_code[g])
      );
    end else begin : g_body
      tws_cell #(.SW(SW)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .d_valid    (c_valid[g+1]),
        .d_periodic (c_periodic[g+1]),
        .d_slot     (c_slot[g+1]),
        .d_pmod     (c_pmod[g+1]),
        .d_code     (c_code[g+1]),
        .q_valid    (c_valid[g]),
        .q_periodic (c_periodic[g]),
        .q_slot     (c_slot[g]),
        .q_pmod     (c_pmod[g]),
        .q_code     (c_code[g])
      );
    end
  end

  tws_head #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .TASK_ENTRIES (TASK_ENTRIES),
    .SW           (SW),
    .IW           (IW)
  ) u_head (
    .ctl          (ctl),
    .idx          (idx),
    .target_id    (tgt_r),
    .pos          (pos),
    .add_slot     (add_slot),
    .add_pmod     (add_pmod),
    .add_periodic (add_periodic),
    .add_code     (code_r),
    .in_valid     (c_valid[0]),
    .in_periodic  (c_periodic[0]),
    .in_slot      (c_slot[0]),
    .in_pmod      (c_pmod[0]),
    .in_code      (c_code[0]),
    .out_valid    (h_valid),
    .out_periodic (h_periodic),
    .out_slot     (h_slot),
    .out_pmod     (h_pmod),
    .out_code     (h_code),
    .evt          (evt)
  );

  // Command sequencer, divider passes and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= '0;
      idx    <= '0;
      strobe <= 1'b0;
      div_go <= 1'b0;
      pend_v <= 1'b0;
      placed <= 1'b0;
      del_ok <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r   <= opcode;
            code_r <= task_code;
            per_r  <= period_ms;
            tgt_r  <= target_id;
            idx    <= '0;
            placed <= 1'b0;
            del_ok <= 1'b0;
            pend_v <= 1'b0;
            if (opcode == OP_ADD) begin
              div_go    <= 1'b1;
              div_dvd   <= DVD_W'(delay_ms);
              div_wheel <= 1'b0;
              state     <= S_DIV_DLY;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DIV_DLY: begin
          // delay ticks plus position, reduced modulo the wheel
          if (div_done) begin
            div_go    <= 1'b1;
            div_dvd   <= div_quo + DVD_W'(pos);
            div_wheel <= 1'b1;
            state     <= S_DIV_SLOT;
          end
        end
        S_DIV_SLOT: begin
          if (div_done) begin
            add_slot  <= SW'(div_rem);
            div_go    <= 1'b1;
            div_dvd   <= DVD_W'(per_r);
            div_wheel <= 1'b0;
            state     <= S_DIV_PER;
          end
        end
        S_DIV_PER: begin
          // saturate period ticks, then reduce modulo the wheel
          if (div_done) begin
            add_periodic <= (div_quo != '0);
            div_go       <= 1'b1;
            div_dvd      <= (div_quo > DVD_W'(PERIOD_MAX)) ? DVD_W'(PERIOD_MAX) : div_quo;
            div_wheel    <= 1'b1;
            state        <= S_DIV_PMOD;
          end
        end
        S_DIV_PMOD: begin
          if (div_done) begin
            add_pmod <= SW'(div_rem);
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (evt.place) begin
            placed   <= 1'b1;
            place_id <= idx;
          end
          if (evt.drop) begin
            del_ok <= 1'b1;
          end
          // a firing is held back one step so the final one can carry last
          if (evt.fire) begin
            if (pend_v) begin
              strobe      <= 1'b1;
              status      <= ST_OK;
              assigned_id <= '0;
              fired       <= 1'b1;
              fired_code  <= pend_code;
              last        <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_code <= c_code[0];
          end
          if (idx == IW'(TASK_ENTRIES - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          strobe      <= 1'b1;
          status      <= ST_OK;
          assigned_id <= '0;
          fired       <= 1'b0;
          fired_code  <= '0;
          last        <= 1'b1;
          case (op_r)
            OP_ADD: begin
              if (placed) begin
                assigned_id <= 4'(place_id);
              end else begin
                status <= ST_FULL;
              end
            end
            OP_TICK: begin
              pos <= (pos == SW'(WHEEL_SLOTS - 1)) ? '0 : pos + 1'b1;
              if (pend_v) begin
                fired      <= 1'b1;
                fired_code <= pend_code;
              end
            end
            OP_DEL: begin
              if (!del_ok) begin
                status <= ST_NOTFOUND;
              end
            end
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result issued while idle");

  a_div_in_prep: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_DLY || state == S_DIV_SLOT ||
                  state == S_DIV_PER || state == S_DIV_PMOD))
    else $error("divider finished outside an add");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (SW+1)'(pos) < (SW+1)'(WHEEL_SLOTS))
    else $error("wheel position out of range");

  a_head_evt: assert property (@(posedge clk) disable iff (rst)
    shift |-> $onehot0({evt.fire, evt.place, evt.drop}))
    else $error("head raised more than one event");

endmodule

### rtl/tws_div.sv
module tws_div import tws_pkg::*; #(
  parameter int TICK_MS     = TICK_MS_DEF,
  parameter int WHEEL_SLOTS = WHEEL_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic             by_wheel,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  // Scaled reciprocals: (x * RCP) >> 32 gives the quotient or one below it
  localparam logic [31:0] RCP_TICK  = 32'(64'hFFFF_FFFF / 64'(TICK_MS));
  localparam logic [31:0] RCP_WHEEL = 32'(64'hFFFF_FFFF / 64'(WHEEL_SLOTS));
  localparam int          PW        = DVD_W + 32;

  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [DVD_W-1:0]       x_r;
  logic [DVS_W-1:0]       d_r;
  logic [31:0]            m_r;
  logic [PW-1:0]          prod;
  logic [DVD_W-1:0]       q0;
  logic [DVD_W-1:0]       qd;
  logic [DVD_W-1:0]       quo;
  logic [DVS_W-1:0]       rem;

  logic [DVD_W+DVS_W-1:0] qd_full;
  logic [DVD_W-1:0]       r0;
  logic                   fix;

  // Back-multiply the estimate and check the leftover against the divisor
  always_comb begin
    qd_full = prod[PW-1:32] * d_r;
    r0      = x_r - qd;
    fix     = r0 >= DVD_W'(d_r);
  end

  // Stage flags: load, multiply, back-multiply, correct
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Data path, one step per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= dividend;
      d_r <= by_wheel ? DVS_W'(WHEEL_SLOTS) : DVS_W'(TICK_MS);
      m_r <= by_wheel ? RCP_WHEEL : RCP_TICK;
    end
    if (v1) begin
      prod <= x_r * m_r;
    end
    if (v2) begin
      q0 <= prod[PW-1:32];
      qd <= qd_full[DVD_W-1:0];
    end
    if (v3) begin
      // estimate one short: bump quotient, take divisor off the remainder
      quo <= fix ? q0 + 1'b1 : q0;
      rem <= fix ? DVS_W'(r0 - DVD_W'(d_r)) : DVS_W'(r0);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/tws_cell.sv
module tws_cell import tws_pkg::*; #(
  parameter int SW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          d_valid,
  input  logic          d_periodic,
  input  logic [SW-1:0] d_slot,
  input  logic [SW-1:0] d_pmod,
  input  logic [7:0]    d_code,
  output logic          q_valid,
  output logic          q_periodic,
  output logic [SW-1:0] q_slot,
  output logic [SW-1:0] q_pmod,
  output logic [7:0]    q_code
);

  // Valid flag cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (shift) begin
      q_valid <= d_valid;
    end
  end

  // Entry payload, taken over from the neighbour on each ring step
  always_ff @(posedge clk) begin
    if (shift) begin
      q_periodic <= d_periodic;
      q_slot     <= d_slot;
      q_pmod     <= d_pmod;
      q_code     <= d_code;
    end
  end

endmodule

### rtl/tws_head.sv
module tws_head import tws_pkg::*; #(
  parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
  parameter int TASK_ENTRIES = TASK_ENTRIES_DEF,
  parameter int SW           = $clog2(WHEEL_SLOTS),
  parameter int IW           = $clog2(TASK_ENTRIES)
) (
  input  head_ctl_t     ctl,
  input  logic [IW-1:0] idx,
  input  logic [3:0]    target_id,
  input  logic [SW-1:0] pos,
  input  logic [SW-1:0] add_slot,
  input  logic [SW-1:0] add_pmod,
  input  logic          add_periodic,
  input  logic [7:0]    add_code,
  input  logic          in_valid,
  input  logic          in_periodic,
  input  logic [SW-1:0] in_slot,
  input  logic [SW-1:0] in_pmod,
  input  logic [7:0]    in_code,
  output logic          out_valid,
  output logic          out_periodic,
  output logic [SW-1:0] out_slot,
  output logic [SW-1:0] out_pmod,
  output logic [7:0]    out_code,
  output head_evt_t     evt
);

  localparam int CW = (IW > 4) ? IW : 4;

  logic [SW:0] resum;

  // Apply the current command to the entry leaving the ring head
  always_comb begin
    out_valid    = in_valid;
    out_periodic = in_periodic;
    out_slot     = in_slot;
    out_pmod     = in_pmod;
    out_code     = in_code;
    evt          = '0;
    resum        = {1'b0, pos} + {1'b0, in_pmod};
    case (ctl.opcode)
      OP_ADD: begin
        // first free entry takes the new task
        if (!in_valid && !ctl.placed) begin
          out_valid    = 1'b1;
          out_periodic = add_periodic;
          out_slot     = add_slot;
          out_pmod     = add_pmod;
          out_code     = add_code;
          evt.place    = 1'b1;
        end
      end
      OP_TICK: begin
        if (in_valid && in_slot == pos) begin
          evt.fire = 1'b1;
          if (in_periodic) begin
            // both terms below the wheel size: one conditional subtract
            out_slot = (resum >= (SW+1)'(WHEEL_SLOTS)) ?
                       SW'(resum - (SW+1)'(WHEEL_SLOTS)) : resum[SW-1:0];
          end else begin
            out_valid = 1'b0;
          end
        end
      end
      OP_DEL: begin
        if (in_valid && CW'(target_id) == CW'(idx)) begin
          out_valid = 1'b0;
          evt.drop  = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### bench/timing_wheel_task_scheduler_core_tb.sv
module timing_wheel_task_scheduler_core_tb;
  import tws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare command code, not in the package
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int SLOTS     = WHEEL_SLOTS_DEF;
  localparam int MS_PER_TK = TICK_MS_DEF;
  localparam int ENTRIES   = TASK_ENTRIES_DEF;

  localparam int RANDOM_CMDS = 140;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_code;
    logic [15:0] delay_ms;
    logic [15:0] period_ms;
    logic [3:0]  target_id;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] assigned_id;
    logic       fired;
    logic [7:0] fired_code;
    logic       last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_TICK;
  logic [7:0]  task_code = '0;
  logic [15:0] delay_ms = '0;
  logic [15:0] period_ms = '0;
  logic [3:0]  target_id = '0;
  logic        strobe;
  logic [1:0]  status;
  logic [3:0]  assigned_id;
  logic        fired;
  logic [7:0]  fired_code;
  logic        last;

  sched_cmd_t    pending_cmds[$];
  sched_result_t due_results[$];
  sched_cmd_t    cur_cmd;
  sched_result_t want;
  int            wait_left;
  int            cmds_total;
  int            cmds_accepted;
  int            mismatch_count;
  int            quiet_cycles;

  // Scheduler state as predicted
  logic              tw_valid[ENTRIES];
  logic [6:0]        tw_slot[ENTRIES];
  logic [PER_W-1:0]  tw_period[ENTRIES];
  logic [7:0]        tw_code[ENTRIES];
  logic [6:0]        tw_pos;

  timing_wheel_task_scheduler_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .task_code   (task_code),
    .delay_ms    (delay_ms),
    .period_ms   (period_ms),
    .target_id   (target_id),
    .strobe      (strobe),
    .status      (status),
    .assigned_id (assigned_id),
    .fired       (fired),
    .fired_code  (fired_code),
    .last        (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Works out the results of one command and updates the wheel state
  function automatic void predict_schedule_results(input sched_cmd_t c);
    int            n_fired;
    int            free_idx;
    int unsigned   ticks;
    sched_result_t r;
    r = '0;
    r.last = 1'b1;
    case (c.opcode)
      OP_ADD: begin
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (free_idx < 0 && !tw_valid[i]) free_idx = i;
        if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          ticks = c.period_ms / MS_PER_TK;
          if (ticks > PERIOD_MAX) ticks = 32'(PERIOD_MAX);
          tw_period[free_idx] = ticks[PER_W-1:0];
          ticks = (tw_pos + c.delay_ms / MS_PER_TK) % SLOTS;
          tw_slot[free_idx]  = ticks[6:0];
          tw_code[free_idx]  = c.task_code;
          tw_valid[free_idx] = 1'b1;
          r.status      = ST_OK;
          r.assigned_id = free_idx[3:0];
        end
        due_results.push_back(r);
      end
      OP_TICK: begin
        n_fired = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tw_valid[i] && tw_slot[i] == tw_pos) begin
            r = '0;
            r.fired      = 1'b1;
            r.fired_code = tw_code[i];
            due_results.push_back(r);
            n_fired++;
            if (tw_period[i] != '0) begin
              ticks = (tw_pos + tw_period[i]) % SLOTS;
              tw_slot[i] = ticks[6:0];
            end else begin
              tw_valid[i] = 1'b0;
            end
          end
        end
        ticks = (tw_pos + 1) % SLOTS;
        tw_pos = ticks[6:0];
        if (n_fired == 0) begin
          r = '0;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          due_results[due_results.size()-1].last = 1'b1;
        end
      end
      OP_DEL: begin
        if (tw_valid[c.target_id]) begin
          tw_valid[c.target_id] = 1'b0;
          r.status = ST_OK;
        end else begin
          r.status = ST_NOTFOUND;
        end
        due_results.push_back(r);
      end
      default: begin
        due_results.push_back(r);
      end
    endcase
  endfunction

  function automatic sched_cmd_t rand_cmd(input logic [1:0] op);
    sched_cmd_t c;
    c.opcode    = op;
    c.task_code = 8'($urandom_range(0, 255));
    c.delay_ms  = 16'($urandom_range(0, 65535));
    c.period_ms = 16'($urandom_range(0, 65535));
    c.target_id = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Add with a short first delay so that it fires within the run
  function automatic sched_cmd_t rand_add();
    sched_cmd_t c;
    c = rand_cmd(OP_ADD);
    c.delay_ms = 16'($urandom_range(0, 500));
    case ($urandom_range(0, 4))
      0, 1: c.period_ms = '0;
      2:    c.period_ms = 16'($urandom_range(10, 300));
      3:    c.period_ms = 16'(1000 * $urandom_range(1, 2) + $urandom_range(0, 9));
      default: ;
    endcase
    return c;
  endfunction

  function automatic sched_cmd_t mk_cmd(input logic [1:0] op, input logic [7:0] code,
                                        input logic [15:0] dly, input logic [15:0] per,
                                        input logic [3:0] id);
    sched_cmd_t c;
    c.opcode    = op;
    c.task_code = code;
    c.delay_ms  = dly;
    c.period_ms = per;
    c.target_id = id;
    return c;
  endfunction

  // Command driver: one transfer per start & !busy edge
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      wait_left = 0;
    end else begin
      if (start && !busy) begin
        predict_schedule_results(cur_cmd);
        cmds_accepted++;
        // every third stretch of forty commands runs back to back
        wait_left = ((cmds_accepted / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
      end
      if (!start || !busy) begin
        if (wait_left > 0) begin
          if (!busy) wait_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          opcode    <= cur_cmd.opcode;
          task_code <= cur_cmd.task_code;
          delay_ms  <= cur_cmd.delay_ms;
          period_ms <= cur_cmd.period_ms;
          target_id <= cur_cmd.target_id;
          start     <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (due_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (assigned_id !== want.assigned_id)
          report_mismatch($sformatf("assigned_id %0d, expected %0d",
                                    assigned_id, want.assigned_id));
        if (fired !== want.fired)
          report_mismatch($sformatf("fired %0b, expected %0b", fired, want.fired));
        if (fired_code !== want.fired_code)
          report_mismatch($sformatf("fired_code 0x%02h, expected 0x%02h",
                                    fired_code, want.fired_code));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n_rand;
    int burst;
    int kind;
    bit fill_done;
    for (int i = 0; i < ENTRIES; i++) begin
      tw_valid[i]  = 1'b0;
      tw_slot[i]   = '0;
      tw_period[i] = '0;
      tw_code[i]   = '0;
    end
    tw_pos         = '0;
    cmds_accepted  = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    wait_left      = 0;

    // Directed: empty tick, unknown delete, one-shot, extremes, lap period,
    // same-slot firing order, delay truncation and wrap, spare opcode
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_DEL,  8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'h00, 16'd0,    16'd0,    4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'hA5, 16'd9,    16'd1000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'h5A, 16'd10,   16'd10,   4'd0));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'h3C, 16'd10,   16'd0,    4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_DEL,  8'h00, 16'h0000, 16'h0000, 4'd2));
    pending_cmds.push_back(mk_cmd(OP_DEL,  8'h00, 16'h0000, 16'h0000, 4'd2));
    pending_cmds.push_back(mk_cmd(OP_DEL,  8'hFF, 16'hFFFF, 16'hFFFF, 4'd15));
    pending_cmds.push_back(mk_cmd(OP_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
    pending_cmds.push_back(mk_cmd(OP_SPARE, 8'h00, 16'h0000, 16'h0000, 4'h0));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'h81, 16'd990,  16'd19,   4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_DEL,  8'h00, 16'h0000, 16'h0000, 4'd0));
    pending_cmds.push_back(mk_cmd(OP_ADD,  8'h42, 16'd1000, 16'd0,    4'd0));
    pending_cmds.push_back(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0));

    // Random: bursts of adds and ticks, deletes, table fills, noise
    n_rand    = 0;
    fill_done = 1'b0;
    while (n_rand < RANDOM_CMDS) begin
      kind = fill_done ? $urandom_range(0, 9) : 7;
      case (kind)
        0, 1: begin
          burst = $urandom_range(2, 6);
          repeat (burst) pending_cmds.push_back(rand_add());
        end
        2, 3, 4, 5: begin
          burst = $urandom_range(5, 25);
          repeat (burst) pending_cmds.push_back(rand_cmd(OP_TICK));
        end
        6: begin
          burst = $urandom_range(1, 3);
          repeat (burst) pending_cmds.push_back(rand_cmd(OP_DEL));
        end
        7: begin
          burst = ENTRIES + 2;
          repeat (burst) pending_cmds.push_back(rand_add());
          fill_done = 1'b1;
        end
        8: begin
          burst = 1;
          pending_cmds.push_back(rand_cmd($urandom_range(0, 1) ? OP_SPARE : OP_ADD));
        end
        default: begin
          burst = 1;
          pending_cmds.push_back(rand_cmd(2'($urandom_range(0, 3))));
        end
      endcase
      n_rand += burst;
    end
    cmds_total = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted != cmds_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### timing_wheel_task_scheduler_core.f
rtl/tws_pkg.sv
rtl/tws_div.sv
rtl/tws_cell.sv
rtl/tws_head.sv
rtl/timing_wheel_task_scheduler_core.sv
bench/timing_wheel_task_scheduler_core_tb.sv
